FILE: rtl/ocr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ocr_pkg;

    localparam int KEY_W        = 32;
    localparam int NU_W         = 32;
    localparam int STAMP_W      = 32;
    localparam int CAP_W        = 5;
    localparam int MAX_CAPACITY = 64;
    localparam int IDX_W        = 6;

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [NU_W-1:0]    nu_t;
    typedef logic [STAMP_W-1:0] stamp_t;

    // Running result of the search as it walks along the row of cells.
    typedef struct packed {
        logic   valid;
        logic   hit;
        idx_t   hit_idx;
        logic   free_found;
        idx_t   free_idx;
        logic   vic_found;
        idx_t   vic_idx;
        nu_t    best_nu;
        stamp_t best_age;
        key_t   best_key;
    } scan_tok_t;

    // Entry update broadcast to every cell; only the addressed one takes it.
    typedef struct packed {
        logic   en;
        idx_t   idx;
        key_t   key;
        nu_t    next_use;
        stamp_t stamp;
    } cell_wr_t;

endpackage

`default_nettype wire

FILE: rtl/ocr_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ocr_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] key;
    logic        [31:0] next_use;

    modport source (output valid, output key, output next_use, input ready);
    modport sink   (input valid, input key, input next_use, output ready);
endinterface

`default_nettype wire

FILE: rtl/ocr_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ocr_out_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic               evicted;
    logic signed [31:0] evicted_key;

    modport source (output valid, output hit, output evicted, output evicted_key, input ready);
    modport sink   (input valid, input hit, input evicted, input evicted_key, output ready);
endinterface

`default_nettype wire

FILE: rtl/ocr_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module ocr_cell #(
    parameter int INDEX = 0
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ocr_pkg::key_t     req_key,
    input  wire ocr_pkg::stamp_t   now,
    input  wire ocr_pkg::cell_wr_t wr,
    input  wire ocr_pkg::scan_tok_t tok_in,
    output ocr_pkg::scan_tok_t     tok_out
);

    localparam ocr_pkg::idx_t MY_IDX = ocr_pkg::idx_t'(INDEX);

    logic                valid_reg;
    ocr_pkg::key_t       key_reg;
    ocr_pkg::nu_t        nu_reg;
    ocr_pkg::stamp_t     last_reg;
    logic                tok_valid_reg;
    ocr_pkg::scan_tok_t  tok_reg;
    ocr_pkg::scan_tok_t  tok_next;
    ocr_pkg::stamp_t     age;
    logic                match;
    logic                better;
    logic                wr_sel;

    assign wr_sel = wr.en && (wr.idx == MY_IDX);
    assign age    = now - last_reg;
    assign match  = valid_reg && (key_reg == req_key);

    // Strict comparisons keep the earlier slot on a full tie.
    assign better = valid_reg &&
                    (!tok_in.vic_found || (nu_reg > tok_in.best_nu) ||
                     ((nu_reg == tok_in.best_nu) && (age > tok_in.best_age)));

    always_comb
    begin
        tok_next = tok_in;
        if (!tok_in.hit && match)
        begin
            tok_next.hit     = 1'b1;
            tok_next.hit_idx = MY_IDX;
        end
        if (!tok_in.free_found && !valid_reg)
        begin
            tok_next.free_found = 1'b1;
            tok_next.free_idx   = MY_IDX;
        end
        if (better)
        begin
            tok_next.vic_found = 1'b1;
            tok_next.vic_idx   = MY_IDX;
            tok_next.best_nu   = nu_reg;
            tok_next.best_age  = age;
            tok_next.best_key  = key_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_sel)
            begin
                valid_reg <= 1'b1;
            end
            tok_valid_reg <= tok_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_sel)
        begin
            key_reg  <= wr.key;
            nu_reg   <= wr.next_use;
            last_reg <= wr.stamp;
        end
        tok_reg <= tok_next;
    end

    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = tok_valid_reg;
    end

endmodule

`default_nettype wire

FILE: rtl/optimal_next_use_cache_replacer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Fully associative cache tracker with furthest-next-use replacement.
// in_ch carries one access per transaction: a key and the stream position
// of that key's next use (all ones means never again). out_ch returns one
// transaction per access: hit, evicted and the evicted key (zero when
// nothing was evicted). cfg_we/cfg_wdata set the capacity in use; zero is
// taken as one and values above CAPACITY as CAPACITY.
// Each entry lives in its own cell of a row of CAPACITY cells. A search
// token enters the first cell in the cycle after acceptance and moves one
// cell per cycle, collecting hit, free slot and victim on its way. The
// result is captured in res_reg at the end of the row and is then
// registered at the output once the output register is free; in_ch is
// ready again once that result is committed, so a new access is not
// taken before the previous one has passed through the whole cell row.
// Reset empties every entry, clears occupancy and the access count and
// sets the capacity to 16. If the receiver stalls, a finished result
// waits in the output register while the next access is searched; that
// search then holds before its commit until the output register is free.
module optimal_next_use_cache_replacer_top #(
    parameter int CAPACITY = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [4:0] cfg_wdata,
    ocr_in_if.sink          in_ch,
    ocr_out_if.source       out_ch
);

    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (OCC_W > ocr_pkg::CAP_W) ? OCC_W : ocr_pkg::CAP_W;
    localparam logic [CMP_W-1:0] CAP_LIM = CMP_W'(CAPACITY);
    localparam logic [CMP_W-1:0] CAP_MIN = CMP_W'(1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]                  state_reg;
    logic                        start_reg;
    logic [ocr_pkg::CAP_W-1:0]   cap_reg;
    logic [OCC_W-1:0]            occ_reg;
    ocr_pkg::stamp_t             count_reg;
    ocr_pkg::key_t               req_key_reg;
    ocr_pkg::nu_t                req_nu_reg;
    ocr_pkg::scan_tok_t          res_reg;
    logic                        out_valid_reg;
    logic                        out_hit_reg;
    logic                        out_ev_reg;
    ocr_pkg::key_t               out_ev_key_reg;

    ocr_pkg::scan_tok_t          tok [0:CAPACITY];
    ocr_pkg::cell_wr_t           wr;
    logic                        accept;
    logic                        out_free;
    logic                        commit;
    logic                        room;
    logic                        insert;
    logic                        evict;
    logic [CMP_W-1:0]            cap_ext;
    logic [CMP_W-1:0]            eff_cap;

    assign accept   = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign commit   = (state_reg == S_DONE) && out_free;

    always_comb
    begin
        cap_ext = CMP_W'(cap_reg);
        priority if (cap_ext == '0)
        begin
            eff_cap = CAP_MIN;
        end
        else if (cap_ext > CAP_LIM)
        begin
            eff_cap = CAP_LIM;
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    assign room   = CMP_W'(occ_reg) < eff_cap;
    assign insert = !res_reg.hit && room && res_reg.free_found;
    assign evict  = !res_reg.hit && !room && res_reg.vic_found;

    always_comb
    begin
        wr.en       = commit && (res_reg.hit || insert || evict);
        wr.key      = req_key_reg;
        wr.next_use = req_nu_reg;
        wr.stamp    = count_reg;
        priority if (res_reg.hit)
        begin
            wr.idx = res_reg.hit_idx;
        end
        else if (room)
        begin
            wr.idx = res_reg.free_idx;
        end
        else
        begin
            wr.idx = res_reg.vic_idx;
        end
    end

    always_comb
    begin
        tok[0]       = '0;
        tok[0].valid = start_reg;
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        ocr_cell #(
            .INDEX(i)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .req_key(req_key_reg),
            .now    (count_reg),
            .wr     (wr),
            .tok_in (tok[i]),
            .tok_out(tok[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            cap_reg       <= ocr_pkg::CAP_W'(16);
            occ_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            start_reg <= accept;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (tok[CAPACITY].valid)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                        count_reg <= count_reg + ocr_pkg::STAMP_W'(1);
                        if (insert)
                        begin
                            occ_reg <= occ_reg + OCC_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_key_reg <= in_ch.key;
            req_nu_reg  <= in_ch.next_use;
        end
        if ((state_reg == S_SCAN) && tok[CAPACITY].valid)
        begin
            res_reg <= tok[CAPACITY];
        end
        if (commit)
        begin
            out_hit_reg    <= res_reg.hit;
            out_ev_reg     <= evict;
            out_ev_key_reg <= evict ? res_reg.best_key : '0;
        end
    end

    assign in_ch.ready        = (state_reg == S_IDLE);
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.hit         = out_hit_reg;
    assign out_ch.evicted     = out_ev_reg;
    assign out_ch.evicted_key = out_ev_key_reg;

endmodule

`default_nettype wire

FILE: rtl/ocr_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module ocr_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        hit,
    input wire logic        evicted,
    input wire logic [31:0] evicted_key
);

    // A hit never removes an entry.
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && evicted))
        else $error("hit and eviction reported together");

    // Without an eviction the reported key is zero.
    a_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !evicted) |-> (evicted_key == 32'd0))
        else $error("evicted key not zero without eviction");

    // Once an access is taken the block is busy with its search.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready straight after a transaction");

    // A stalled result stays valid and keeps its evicted key.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(evicted_key)))
        else $error("stalled result changed");

endmodule

bind optimal_next_use_cache_replacer_top ocr_chk u_ocr_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .hit        (out_ch.hit),
    .evicted    (out_ch.evicted),
    .evicted_key(out_ch.evicted_key)
);

`default_nettype wire
